### rtl/core/psched_pkg.sv
// Package for the priority scheduler with counting semaphores.
// Holds field widths, event, mode and status codes, and the command and status
// structs between controller and datapath. Depends on nothing.
package psched_pkg;

	// Fixed field widths.
	localparam int PRIO_W       = 7;
	localparam int CNT_W        = 4;
	localparam int OP_W         = 3;
	localparam int MODE_W       = 3;
	localparam int OUT_TASK_W   = 2;
	localparam int STAT_W       = 2;
	localparam int NUM_CFG_REGS = 3;
	localparam int CFG_IDX_W    = 2;

	// Event codes.
	localparam logic [OP_W-1:0] OP_SCHED  = 3'd0;
	localparam logic [OP_W-1:0] OP_WAIT   = 3'd1;
	localparam logic [OP_W-1:0] OP_SIGNAL = 3'd2;
	localparam logic [OP_W-1:0] OP_SLICE  = 3'd3;
	localparam logic [OP_W-1:0] OP_EXIT   = 3'd4;

	// Task modes.
	localparam logic [MODE_W-1:0] MODE_READY   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SLICED  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_WAITING = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RUNNING = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DONE    = 3'd4;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_BLOCKED = 2'd1;
	localparam logic [STAT_W-1:0] ST_WOKEN   = 2'd2;
	localparam logic [STAT_W-1:0] ST_IGNORED = 2'd3;

	// Semaphore count limits and reset value.
	localparam logic signed [CNT_W-1:0] CNT_MIN   = 4'sb1000;
	localparam logic signed [CNT_W-1:0] CNT_MAX   = 4'sb0111;
	localparam logic signed [CNT_W-1:0] CNT_RESET = 4'sb0001;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic scan_step;
		logic walk_step;
		logic commit;
	} psched_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_sched;
		logic need_walk;
		logic scan_last;
		logic walk_done;
		logic out_free;
	} psched_stat_t;

endpackage

### rtl/core/psched_ifs.sv
// Channel interfaces of the priority scheduler: event input and result output.
// Depends on psched_pkg for the field widths.
interface psched_evt_if;
	logic                           valid;
	logic                           ready;
	logic [psched_pkg::OP_W-1:0]    op;
	logic                           sem_index;

	modport source (output valid, output op, output sem_index, input ready);
	modport sink   (input valid, input op, input sem_index, output ready);
endinterface

interface psched_res_if;
	logic                                  valid;
	logic                                  ready;
	logic [psched_pkg::OUT_TASK_W-1:0]     running_task;
	logic [psched_pkg::STAT_W-1:0]         status;
	logic [psched_pkg::OUT_TASK_W-1:0]     woken_task;
	logic signed [psched_pkg::CNT_W-1:0]   sem_value;

	modport source (output valid, output running_task, output status, output woken_task,
		output sem_value, input ready);
	modport sink   (input valid, input running_task, input status, input woken_task,
		input sem_value, output ready);
endinterface

### rtl/core/psched_ctrl.sv
// Controller state machine of the priority scheduler.
// Sequences latch, priority scan, wait-list walk and commit; uses psched_pkg.
module psched_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     evt_valid,
	output logic                     evt_ready,
	input  psched_pkg::psched_stat_t stat,
	output psched_pkg::psched_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_WALK   = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		evt_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				evt_ready = 1'b1;
				if (evt_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.is_sched) begin
					state_d = S_SCAN;
				end else if (stat.need_walk) begin
					state_d = S_WALK;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = S_COMMIT;
				end
			end
			S_WALK: begin
				if (stat.walk_done) begin
					state_d = S_COMMIT;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			S_COMMIT: begin
				// The result register must be free or emptying this cycle.
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A commit never overwrites a result that has not been taken.
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> stat.out_free)
		else $error("commit while result register is occupied");

	// Only a wait event walks a list, never a schedule.
	a_walk_not_sched: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> !stat.is_sched)
		else $error("wait-list walk during a schedule event");

endmodule

### rtl/core/psched_dp.sv
// Datapath of the priority scheduler: task, link and semaphore state, the
// priority registers, scan and walk registers and the result register. Uses psched_pkg.
module psched_dp #(
	parameter int NUM_TASKS = 3,
	parameter int NUM_SEMS  = 2
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [psched_pkg::OP_W-1:0]           evt_op,
	input  logic                                  evt_sem_index,
	input  logic                                  cfg_wr_en,
	input  logic [psched_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [psched_pkg::PRIO_W-1:0]         cfg_wdata,
	input  psched_pkg::psched_cmd_t               cmd,
	output psched_pkg::psched_stat_t              stat,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output logic [psched_pkg::OUT_TASK_W-1:0]     res_running_task,
	output logic [psched_pkg::STAT_W-1:0]         res_status,
	output logic [psched_pkg::OUT_TASK_W-1:0]     res_woken_task,
	output logic signed [psched_pkg::CNT_W-1:0]   res_sem_value
);

	localparam int TW   = $clog2(NUM_TASKS + 1);
	localparam int KW   = $clog2(NUM_TASKS);
	localparam int SW   = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int NCFG = (NUM_TASKS < psched_pkg::NUM_CFG_REGS) ? NUM_TASKS
		: psched_pkg::NUM_CFG_REGS;
	localparam logic [TW-1:0] LAST_TASK = TW'(NUM_TASKS);
	localparam logic [KW-1:0] LAST_IDX  = KW'(NUM_TASKS - 1);

	// Task number (1 based) is valid.
	function automatic logic task_ok(input logic [TW-1:0] t);
		return (t != '0) && (t <= LAST_TASK);
	endfunction

	// Array index of a task number.
	function automatic logic [KW-1:0] idx(input logic [TW-1:0] t);
		logic [TW-1:0] m;
		m = t - TW'(1);
		return m[KW-1:0];
	endfunction

	// Kernel state.
	logic [psched_pkg::PRIO_W-1:0]       prio_q  [NCFG];
	logic [psched_pkg::PRIO_W-1:0]       prio_all [NUM_TASKS];
	logic [psched_pkg::MODE_W-1:0]       mode_q  [NUM_TASKS];
	logic [TW-1:0]                       link_q  [NUM_TASKS];
	logic [TW-1:0]                       head_q  [NUM_SEMS];
	logic signed [psched_pkg::CNT_W-1:0] count_q [NUM_SEMS];
	logic [TW-1:0]                       cur_q;

	// Registers of the event in progress.
	logic [psched_pkg::OP_W-1:0]         op_q;
	logic [SW-1:0]                       s_q;
	logic [TW-1:0]                       icur_q;
	logic signed [psched_pkg::CNT_W-1:0] cnt_q;
	logic [TW-1:0]                       w_q;
	logic [TW-1:0]                       steps_q;
	logic [KW-1:0]                       k_q;
	logic [TW-1:0]                       best_rdy_q;
	logic [psched_pkg::PRIO_W-1:0]       bestp_rdy_q;
	logic [TW-1:0]                       best_slc_q;
	logic [psched_pkg::PRIO_W-1:0]       bestp_slc_q;
	logic [psched_pkg::PRIO_W-1:0]       curp_q;

	// Result register.
	logic                                res_valid_q;
	logic [psched_pkg::OUT_TASK_W-1:0]   res_running_q;
	logic [psched_pkg::STAT_W-1:0]       res_status_q;
	logic [psched_pkg::OUT_TASK_W-1:0]   res_woken_q;
	logic signed [psched_pkg::CNT_W-1:0] res_value_q;

	// Combinational helpers.
	logic [SW-1:0]                       s_in;
	logic [TW-1:0]                       cur_ok;
	logic signed [psched_pkg::CNT_W-1:0] cnt_dec;
	logic signed [psched_pkg::CNT_W-1:0] cnt_inc;
	logic                                active;
	logic                                p_blocks;
	logic                                v_wakes;
	logic [TW-1:0]                       link_w;
	logic [TW-1:0]                       scan_tk;
	logic [psched_pkg::MODE_W-1:0]       scan_mode;
	logic [psched_pkg::PRIO_W-1:0]       scan_prio;
	logic [TW-1:0]                       pd;
	logic [psched_pkg::PRIO_W-1:0]       pdp;
	logic [TW-1:0]                       cur_new;
	logic [psched_pkg::STAT_W-1:0]       status_d;
	logic [TW-1:0]                       woken_d;
	logic signed [psched_pkg::CNT_W-1:0] value_d;

	// Priorities: configurable for the first tasks, fixed beyond them.
	for (genvar g = 0; g < NUM_TASKS; g++) begin : g_prio
		if (g < NCFG) begin : g_cfg
			assign prio_all[g] = prio_q[g];
		end else begin : g_fixed
			assign prio_all[g] = psched_pkg::PRIO_W'(g + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < NCFG; g++) begin
				prio_q[g] <= psched_pkg::PRIO_W'(g + 1);
			end
		end else begin
			for (int g = 0; g < NCFG; g++) begin
				if (cfg_wr_en && (cfg_index == psched_pkg::CFG_IDX_W'(g))) begin
					prio_q[g] <= cfg_wdata;
				end
			end
		end
	end

	// Decoded values of the incoming and latched event.
	assign s_in     = (NUM_SEMS > 1) ? SW'(evt_sem_index) : '0;
	assign cur_ok   = task_ok(cur_q) ? cur_q : '0;
	assign cnt_dec  = (cnt_q != psched_pkg::CNT_MIN) ? cnt_q - 4'sd1 : cnt_q;
	assign cnt_inc  = (cnt_q != psched_pkg::CNT_MAX) ? cnt_q + 4'sd1 : cnt_q;
	assign active   = (icur_q != '0);
	assign p_blocks = cnt_dec[psched_pkg::CNT_W-1];
	assign v_wakes  = (cnt_inc[psched_pkg::CNT_W-1] || (cnt_inc == '0)) && task_ok(w_q);
	assign link_w   = link_q[idx(w_q)];

	// One task of the scan per cycle.
	assign scan_tk   = TW'(k_q) + TW'(1);
	assign scan_mode = mode_q[k_q];
	assign scan_prio = prio_all[k_q];

	// Chosen candidate: a ready task first, else a time-sliced one.
	assign pd  = (best_rdy_q != '0) ? best_rdy_q : best_slc_q;
	assign pdp = (best_rdy_q != '0) ? bestp_rdy_q : bestp_slc_q;

	// Status to the controller.
	assign stat.is_sched  = (op_q == psched_pkg::OP_SCHED);
	assign stat.need_walk = (op_q == psched_pkg::OP_WAIT) && active && p_blocks && task_ok(w_q);
	assign stat.scan_last = (k_q == LAST_IDX);
	assign stat.walk_done = !(task_ok(link_w) && (steps_q < LAST_TASK));
	assign stat.out_free  = !res_valid_q || res_ready;

	// Result of the event.
	always_comb begin
		cur_new  = icur_q;
		status_d = psched_pkg::ST_DONE;
		woken_d  = '0;
		value_d  = cnt_q;
		case (op_q)
			psched_pkg::OP_SCHED: begin
				if (pd != '0) begin
					if (icur_q == '0) begin
						cur_new = pd;
					end else if (pdp < curp_q) begin
						cur_new  = pd;
						status_d = psched_pkg::ST_BLOCKED;
					end
				end
			end
			psched_pkg::OP_WAIT: begin
				if (!active) begin
					status_d = psched_pkg::ST_IGNORED;
				end else begin
					value_d = cnt_dec;
					if (p_blocks) begin
						cur_new  = '0;
						status_d = psched_pkg::ST_BLOCKED;
					end
				end
			end
			psched_pkg::OP_SIGNAL: begin
				if (!active) begin
					status_d = psched_pkg::ST_IGNORED;
				end else begin
					value_d = cnt_inc;
					if (v_wakes) begin
						woken_d  = w_q;
						status_d = psched_pkg::ST_WOKEN;
					end
				end
			end
			psched_pkg::OP_SLICE: begin
				if (!active) begin
					status_d = psched_pkg::ST_IGNORED;
				end else begin
					cur_new  = '0;
					status_d = psched_pkg::ST_BLOCKED;
				end
			end
			psched_pkg::OP_EXIT: begin
				if (!active) begin
					status_d = psched_pkg::ST_IGNORED;
				end else begin
					cur_new = '0;
				end
			end
			default: begin
				cur_new = icur_q;
			end
		endcase
	end

	// Kernel state: updated only when the event commits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TASKS; t++) begin
				mode_q[t] <= psched_pkg::MODE_READY;
				link_q[t] <= '0;
			end
			for (int s = 0; s < NUM_SEMS; s++) begin
				head_q[s]  <= '0;
				count_q[s] <= psched_pkg::CNT_RESET;
			end
			cur_q <= '0;
		end else if (cmd.commit) begin
			cur_q <= cur_new;
			case (op_q)
				psched_pkg::OP_SCHED: begin
					if (pd != '0) begin
						if (icur_q == '0) begin
							mode_q[idx(pd)] <= psched_pkg::MODE_RUNNING;
						end else if (pdp < curp_q) begin
							mode_q[idx(icur_q)] <= psched_pkg::MODE_READY;
							mode_q[idx(pd)]     <= psched_pkg::MODE_RUNNING;
						end
					end
				end
				psched_pkg::OP_WAIT: begin
					if (active) begin
						count_q[s_q] <= cnt_dec;
						if (p_blocks) begin
							mode_q[idx(icur_q)] <= psched_pkg::MODE_WAITING;
							link_q[idx(icur_q)] <= '0;
							// Append to the tail found by the walk, or start the list.
							if (!task_ok(w_q)) begin
								head_q[s_q] <= icur_q;
							end else begin
								link_q[idx(w_q)] <= icur_q;
							end
						end
					end
				end
				psched_pkg::OP_SIGNAL: begin
					if (active) begin
						count_q[s_q] <= cnt_inc;
						if (v_wakes) begin
							head_q[s_q]      <= link_w;
							link_q[idx(w_q)] <= '0;
							mode_q[idx(w_q)] <= psched_pkg::MODE_READY;
						end
					end
				end
				psched_pkg::OP_SLICE: begin
					if (active) begin
						mode_q[idx(icur_q)] <= psched_pkg::MODE_SLICED;
					end
				end
				psched_pkg::OP_EXIT: begin
					if (active) begin
						mode_q[idx(icur_q)] <= psched_pkg::MODE_DONE;
					end
				end
				default: begin
					// Unused codes leave the task and semaphore state alone.
				end
			endcase
		end
	end

	// Event registers: latch, priority scan and list walk.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q       <= evt_op;
			s_q        <= s_in;
			icur_q     <= cur_ok;
			cnt_q      <= count_q[s_in];
			w_q        <= head_q[s_in];
			steps_q    <= '0;
			k_q        <= '0;
			best_rdy_q <= '0;
			best_slc_q <= '0;
			curp_q     <= '0;
		end
		if (cmd.scan_step) begin
			if ((scan_mode == psched_pkg::MODE_READY)
				&& ((best_rdy_q == '0) || (scan_prio < bestp_rdy_q))) begin
				best_rdy_q  <= scan_tk;
				bestp_rdy_q <= scan_prio;
			end
			if ((scan_mode == psched_pkg::MODE_SLICED)
				&& ((best_slc_q == '0) || (scan_prio < bestp_slc_q))) begin
				best_slc_q  <= scan_tk;
				bestp_slc_q <= scan_prio;
			end
			if (scan_tk == icur_q) begin
				curp_q <= scan_prio;
			end
			if (k_q != LAST_IDX) begin
				k_q <= k_q + 1'b1;
			end
		end
		if (cmd.walk_step) begin
			w_q     <= link_w;
			steps_q <= steps_q + 1'b1;
		end
	end

	// Result register: one beat per event, held until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_running_q <= cur_new[psched_pkg::OUT_TASK_W-1:0];
			res_status_q  <= status_d;
			res_woken_q   <= woken_d[psched_pkg::OUT_TASK_W-1:0];
			res_value_q   <= value_d;
		end
	end

	assign res_valid        = res_valid_q;
	assign res_running_task = res_running_q;
	assign res_status       = res_status_q;
	assign res_woken_task   = res_woken_q;
	assign res_sem_value    = res_value_q;

	// The running task is always marked running.
	a_cur_running: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q != '0) |-> (mode_q[idx(cur_q)] == psched_pkg::MODE_RUNNING))
		else $error("running task not in running mode");

	// A non-empty wait list on semaphore 0 goes with a negative count.
	a_head_negative: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q[0] != '0) |-> count_q[0][psched_pkg::CNT_W-1])
		else $error("waiters queued on a semaphore with non-negative count");

	// Every commit presents a result beat.
	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> res_valid_q)
		else $error("commit without a result beat");

endmodule

### rtl/core/priority_scheduler_with_semaphores.sv
// Priority scheduler with counting semaphores. One event in, one result beat out.
// Sequence: a schedule latches, decides, scans one task per cycle and commits; wait,
// signal, slice end and exit latch, decide and commit; a blocking wait behind earlier
// waiters walks the list first. The commit waits while a result is not taken.
// Throughput: one event at a time; a new one is taken the cycle after the commit.
// Reset: asynchronous; kernel state and priorities return to reset values at once.
module priority_scheduler_with_semaphores #(
	parameter int NUM_TASKS = 3,
	parameter int NUM_SEMS  = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	psched_evt_if.sink                        evt,
	psched_res_if.source                      res,
	input  logic                              cfg_wr_en,
	input  logic [psched_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psched_pkg::PRIO_W-1:0]     cfg_wdata
);

	psched_pkg::psched_cmd_t  cmd;
	psched_pkg::psched_stat_t stat;

	// Sequencing of each event.
	psched_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// State, scan, walk and result register.
	psched_dp #(
		.NUM_TASKS (NUM_TASKS),
		.NUM_SEMS  (NUM_SEMS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.evt_op           (evt.op),
		.evt_sem_index    (evt.sem_index),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.cmd              (cmd),
		.stat             (stat),
		.res_valid        (res.valid),
		.res_ready        (res.ready),
		.res_running_task (res.running_task),
		.res_status       (res.status),
		.res_woken_task   (res.woken_task),
		.res_sem_value    (res.sem_value)
	);

endmodule

### tb/sv/priority_scheduler_with_semaphores_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the priority scheduler with counting semaphores.
// Predicts each result beat from the event stream and compares field by field.
// Depends on psched_pkg, psched_ifs and the scheduler top level.
module priority_scheduler_with_semaphores_tb;
	import psched_pkg::*;

	localparam int N_TASKS        = 3;
	localparam int N_SEMS         = 2;
	localparam int STALL_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 20;

	typedef struct {
		logic [OUT_TASK_W-1:0]   running_task;
		logic [STAT_W-1:0]       status;
		logic [OUT_TASK_W-1:0]   woken_task;
		logic signed [CNT_W-1:0] sem_value;
	} sched_result_t;

	// Scoreboard: a private copy of the kernel state and the queue of expected beats.
	class sched_scoreboard;
		logic [PRIO_W-1:0]       prio [N_TASKS];
		logic [MODE_W-1:0]       mode [N_TASKS];
		logic [OUT_TASK_W-1:0]   link [N_TASKS];
		logic [OUT_TASK_W-1:0]   head [N_SEMS];
		logic signed [CNT_W-1:0] count [N_SEMS];
		logic [OUT_TASK_W-1:0]   running;
		sched_result_t           pending [$];
		int                      errors;

		function new();
			for (int k = 0; k < N_TASKS; k++) begin
				prio[k] = PRIO_W'(k + 1);
				mode[k] = MODE_READY;
				link[k] = '0;
			end
			for (int k = 0; k < N_SEMS; k++) begin
				head[k]  = '0;
				count[k] = CNT_RESET;
			end
			running = '0;
			errors  = 0;
		endfunction

		function void set_prio(int idx, logic [PRIO_W-1:0] value);
			if (idx < N_TASKS)
				prio[idx] = value;
		endfunction

		// Best task in a mode: lowest priority number, ties to the lowest task number.
		function int best_in_mode(logic [MODE_W-1:0] m);
			int best;
			best = 0;
			for (int k = 0; k < N_TASKS; k++)
				if (mode[k] == m && (best == 0 || prio[k] < prio[best-1]))
					best = k + 1;
			return best;
		endfunction

		// True when some task other than the running one could be scheduled.
		function bit others_runnable();
			return best_in_mode(MODE_READY) != 0 || best_in_mode(MODE_SLICED) != 0;
		endfunction

		// Appends a task to the tail of a semaphore's wait list.
		function void add_waiter(int s, int t);
			int w;
			int steps;
			link[t-1] = '0;
			w = head[s];
			steps = 0;
			if (w == 0) begin
				head[s] = OUT_TASK_W'(t);
			end else begin
				while (link[w-1] != 0 && steps < N_TASKS) begin
					w = link[w-1];
					steps++;
				end
				link[w-1] = OUT_TASK_W'(t);
			end
		endfunction

		// Applies one accepted event and queues the beat it must produce.
		function void note_event(logic [OP_W-1:0] op, logic sem);
			sched_result_t res;
			int cur;
			int pick;
			int s;
			int w;
			cur = running;
			s = sem;
			res.status = ST_DONE;
			res.woken_task = '0;
			if (op == OP_SCHED) begin
				pick = best_in_mode(MODE_READY);
				if (pick == 0)
					pick = best_in_mode(MODE_SLICED);
				if (pick != 0) begin
					if (cur == 0) begin
						mode[pick-1] = MODE_RUNNING;
						cur = pick;
					end else if (prio[pick-1] < prio[cur-1]) begin
						mode[cur-1]  = MODE_READY;
						mode[pick-1] = MODE_RUNNING;
						cur = pick;
						res.status = ST_BLOCKED;
					end
				end
			end else if (op <= OP_EXIT && cur == 0) begin
				res.status = ST_IGNORED;
			end else if (op == OP_WAIT) begin
				if (count[s] > CNT_MIN)
					count[s] = count[s] - 4'sd1;
				if (count[s] < 0) begin
					mode[cur-1] = MODE_WAITING;
					add_waiter(s, cur);
					cur = 0;
					res.status = ST_BLOCKED;
				end
			end else if (op == OP_SIGNAL) begin
				if (count[s] < CNT_MAX)
					count[s] = count[s] + 4'sd1;
				if (count[s] <= 0 && head[s] != 0) begin
					w = head[s];
					head[s] = link[w-1];
					link[w-1] = '0;
					mode[w-1] = MODE_READY;
					res.woken_task = OUT_TASK_W'(w);
					res.status = ST_WOKEN;
				end
			end else if (op == OP_SLICE) begin
				mode[cur-1] = MODE_SLICED;
				cur = 0;
				res.status = ST_BLOCKED;
			end else if (op == OP_EXIT) begin
				mode[cur-1] = MODE_DONE;
				cur = 0;
			end
			running = OUT_TASK_W'(cur);
			res.running_task = running;
			res.sem_value = count[s];
			pending.push_back(res);
		endfunction

		function void match_field(string name, logic signed [3:0] want, logic signed [3:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		// Compares an accepted result beat with the oldest expectation.
		function void check_result(sched_result_t got);
			sched_result_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, expected none, actual %0d/%0d/%0d/%0d",
					$time, got.running_task, got.status, got.woken_task, got.sem_value);
			end else begin
				want = pending.pop_front();
				match_field("running_task", 4'(want.running_task), 4'(got.running_task));
				match_field("status", 4'(want.status), 4'(got.status));
				match_field("woken_task", 4'(want.woken_task), 4'(got.woken_task));
				match_field("sem_value", want.sem_value, got.sem_value);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PRIO_W-1:0]    cfg_wdata;
	bit                   quiet;
	int                   stall_left;
	int                   idle_cycles;
	sched_scoreboard      sb;

	psched_evt_if evt_ch ();
	psched_res_if res_ch ();

	priority_scheduler_with_semaphores u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt_ch),
		.res       (res_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Clock with a period of 4 ns.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side back-pressure: random stall bursts, none in the quiet part.
	always @(negedge clk) begin
		if (quiet) begin
			res_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 19) - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Result monitor: every accepted beat is checked.
	always @(posedge clk) begin
		sched_result_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.running_task = res_ch.running_task;
			got.status       = res_ch.status;
			got.woken_task   = res_ch.woken_task;
			got.sem_value    = res_ch.sem_value;
			sb.check_result(got);
		end
	end

	// Watchdog on cycles in which no beat moves on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Drives one event beat and records it once accepted.
	task automatic send_event(input logic [OP_W-1:0] op, input logic sem);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			evt_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		evt_ch.valid     <= 1'b1;
		evt_ch.op        <= op;
		evt_ch.sem_index <= sem;
		@(posedge clk);
		while (!evt_ch.ready)
			@(posedge clk);
		sb.note_event(op, sem);
		@(negedge clk);
	endtask

	// Holds the sender off until every expected beat has arrived.
	task automatic wait_drained();
		evt_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
	endtask

	// Rewrites the priorities while the block is idle; optionally hits the spare index.
	task automatic program_prios(input logic [PRIO_W-1:0] p0, p1, p2, input bit poke_spare);
		logic [PRIO_W-1:0] vals [4];
		int n;
		vals[0] = p0;
		vals[1] = p1;
		vals[2] = p2;
		vals[3] = PRIO_W'($urandom);
		n = poke_spare ? 4 : 3;
		wait_drained();
		for (int i = 0; i < n; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_wdata <= vals[i];
			sb.set_prio(i, vals[i]);
			@(negedge clk);
		end
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Random events shaped by the predicted state so that the kernel never deadlocks
	// on its semaphores; task exits only where allowed.
	task automatic run_random(input int n, input bit allow_exit);
		logic [OP_W-1:0] op;
		logic sem;
		int r;
		for (int i = 0; i < n; i++) begin
			sem = 1'($urandom_range(0, 1));
			r = $urandom_range(0, 99);
			if (sb.running == 0) begin
				op = (r < 80) ? OP_SCHED : OP_W'($urandom_range(1, 7));
			end else if (r < 28) begin
				// A blocking wait with nobody left to run would stall the kernel for good.
				if (sb.count[sem] <= 0 && !sb.others_runnable())
					op = OP_SIGNAL;
				else
					op = OP_WAIT;
			end else if (r < 58) begin
				op = OP_SIGNAL;
			end else if (r < 76) begin
				op = OP_SCHED;
			end else if (r < 86) begin
				op = OP_SLICE;
			end else if (r < 92) begin
				op = OP_W'($urandom_range(5, 7));
			end else begin
				op = allow_exit ? OP_EXIT : OP_SCHED;
			end
			send_event(op, sem);
		end
	endtask

	initial begin
		sb = new();
		quiet = 1'b0;
		stall_left = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		evt_ch.valid = 1'b0;
		evt_ch.op = OP_SCHED;
		evt_ch.sem_index = 1'b0;
		res_ch.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: events with no task running are ignored, unused codes do nothing.
		send_event(OP_WAIT, 1'b0);
		send_event(OP_SIGNAL, 1'b1);
		send_event(OP_SLICE, 1'b0);
		send_event(OP_EXIT, 1'b1);
		send_event(OP_W'(7), 1'b1);
		// First schedule, then one with no better task.
		send_event(OP_SCHED, 1'b0);
		send_event(OP_SCHED, 1'b1);
		// Wait that does not block, then one that does; a signal wakes the waiter.
		send_event(OP_WAIT, 1'b0);
		send_event(OP_WAIT, 1'b0);
		send_event(OP_SCHED, 1'b0);
		send_event(OP_SIGNAL, 1'b0);
		// Woken task preempts the running one.
		send_event(OP_SCHED, 1'b0);
		// Slice ends until no task is ready, then the pick falls to sliced tasks.
		send_event(OP_SLICE, 1'b0);
		send_event(OP_SCHED, 1'b1);
		send_event(OP_SLICE, 1'b1);
		send_event(OP_SCHED, 1'b0);
		send_event(OP_SLICE, 1'b0);
		send_event(OP_SCHED, 1'b1);
		// Signals until the count saturates at its maximum.
		repeat (7) send_event(OP_SIGNAL, 1'b1);

		// Random phases under several priority settings.
		run_random(120, 1'b0);
		program_prios(7'd0, 7'd0, 7'd0, 1'b0);
		run_random(100, 1'b0);
		program_prios(7'd127, 7'd0, 7'd64, 1'b0);
		run_random(100, 1'b0);
		program_prios(7'd99, 7'd50, 7'd1, 1'b0);
		run_random(100, 1'b0);
		program_prios(PRIO_W'($urandom), PRIO_W'($urandom), PRIO_W'($urandom), 1'b1);
		run_random(100, 1'b0);

		// Closing part at full rate: tasks exit until nothing is left to schedule.
		program_prios(7'd127, 7'd127, 7'd127, 1'b0);
		quiet = 1'b1;
		run_random(80, 1'b1);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

### sim.f
rtl/core/psched_pkg.sv
rtl/core/psched_ifs.sv
rtl/core/psched_ctrl.sv
rtl/core/psched_dp.sv
rtl/core/priority_scheduler_with_semaphores.sv
tb/sv/priority_scheduler_with_semaphores_tb.sv
